>>> sv/aoe_pkg.sv
package aoe_pkg;

    // register indexes on the configuration channel
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH     = 1'b0,
        CFG_ALPHA_THRESHOLD = 1'b1
    } cfg_index_t;

    localparam logic [12:0] WIDTH_RST     = 13'd4096;
    localparam logic [7:0]  THRESHOLD_RST = 8'd92;
    localparam logic [12:0] ROW_SAT       = 13'h1FFF;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // line store write side: opacity history and edge bit of one column
    typedef struct packed {
        logic       opq_en;
        logic [2:0] opq_data;
        logic       edge_en;
        logic       edge_data;
    } line_wr_t;

    // line store read side, already forwarded and fill-checked
    typedef struct packed {
        logic [2:0] opq_here;
        logic [2:0] opq_side;
        logic       edge_above;
    } line_rd_t;

    typedef struct packed {
        logic        last;
        logic [11:0] row;
        logic [11:0] col;
        logic        outline;
    } result_t;

endpackage

>>> sv/aoe_line_store.sv
module aoe_line_store #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr_here,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr_side,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  aoe_pkg::line_wr_t               wr,
    output aoe_pkg::line_rd_t               rd
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [2:0] opq_mem  [MAX_WIDTH];
    logic       edge_mem [MAX_WIDTH];

    logic [2:0]  opq_q_here_reg;
    logic [2:0]  opq_q_side_reg;
    logic        edge_q_reg;
    logic [CW-1:0] ra_here_reg;
    logic [CW-1:0] ra_side_reg;

    // most recent write per store, for read-during-write forwarding
    logic [CW-1:0] opq_wa_reg;
    logic [2:0]    opq_wd_reg;
    logic          opq_wv_reg;
    logic [CW-1:0] edge_wa_reg;
    logic          edge_wd_reg;
    logic          edge_wv_reg;

    // entries at or above the fill count were never written and read as zero
    logic [CW:0] opq_fill_reg;
    logic [CW:0] opq_fill_next;
    logic [CW:0] edge_fill_reg;
    logic [CW:0] edge_fill_next;

    always_ff @(posedge clk)
    begin
        if (wr.opq_en)
        begin
            opq_mem[wr_addr] <= wr.opq_data;
        end
        if (wr.edge_en)
        begin
            edge_mem[wr_addr] <= wr.edge_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            opq_q_here_reg <= opq_mem[rd_addr_here];
            opq_q_side_reg <= opq_mem[rd_addr_side];
            edge_q_reg     <= edge_mem[rd_addr_here];
            ra_here_reg    <= rd_addr_here;
            ra_side_reg    <= rd_addr_side;
        end
        if (wr.opq_en)
        begin
            opq_wa_reg <= wr_addr;
            opq_wd_reg <= wr.opq_data;
        end
        if (wr.edge_en)
        begin
            edge_wa_reg <= wr_addr;
            edge_wd_reg <= wr.edge_data;
        end
    end

    always_comb
    begin
        opq_fill_next  = opq_fill_reg;
        edge_fill_next = edge_fill_reg;
        if (wr.opq_en && ({1'b0, wr_addr} >= opq_fill_reg))
        begin
            opq_fill_next = {1'b0, wr_addr} + 1'b1;
        end
        if (wr.edge_en && ({1'b0, wr_addr} >= edge_fill_reg))
        begin
            edge_fill_next = {1'b0, wr_addr} + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opq_wv_reg    <= 1'b0;
            edge_wv_reg   <= 1'b0;
            opq_fill_reg  <= '0;
            edge_fill_reg <= '0;
        end
        else
        begin
            if (wr.opq_en)
            begin
                opq_wv_reg <= 1'b1;
            end
            if (wr.edge_en)
            begin
                edge_wv_reg <= 1'b1;
            end
            opq_fill_reg  <= opq_fill_next;
            edge_fill_reg <= edge_fill_next;
        end
    end

    always_comb
    begin
        if (opq_wv_reg && (opq_wa_reg == ra_here_reg))
            rd.opq_here = opq_wd_reg;
        else if ({1'b0, ra_here_reg} < opq_fill_reg)
            rd.opq_here = opq_q_here_reg;
        else
            rd.opq_here = 3'b000;

        if (opq_wv_reg && (opq_wa_reg == ra_side_reg))
            rd.opq_side = opq_wd_reg;
        else if ({1'b0, ra_side_reg} < opq_fill_reg)
            rd.opq_side = opq_q_side_reg;
        else
            rd.opq_side = 3'b000;

        if (edge_wv_reg && (edge_wa_reg == ra_here_reg))
            rd.edge_above = edge_wd_reg;
        else if ({1'b0, ra_here_reg} < edge_fill_reg)
            rd.edge_above = edge_q_reg;
        else
            rd.edge_above = 1'b0;
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (opq_fill_reg <= (CW+1)'(MAX_WIDTH)) && (edge_fill_reg <= (CW+1)'(MAX_WIDTH)))
        else $error("line store fill count beyond depth");

endmodule

>>> sv/aoe_out_fifo.sv
module aoe_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  aoe_pkg::result_t                  push_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output aoe_pkg::result_t                  out_data,
    output logic [aoe_pkg::OUT_CNT_W-1:0]     count
);

    aoe_pkg::result_t buf_reg [aoe_pkg::OUT_DEPTH];

    logic [aoe_pkg::OUT_PTR_W-1:0] wr_ptr_reg;
    logic [aoe_pkg::OUT_PTR_W-1:0] rd_ptr_reg;
    logic [aoe_pkg::OUT_CNT_W-1:0] cnt_reg;
    logic [aoe_pkg::OUT_CNT_W-1:0] cnt_next;
    logic                          pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < aoe_pkg::OUT_CNT_W'(aoe_pkg::OUT_DEPTH)) || pop)
        else $error("result queue written while full");

endmodule

>>> sv/alpha_outline_extractor.sv
// An accepted word is registered into stage B, which pushes its result into the queue.
// Throughput: one word per cycle while the queue has room; line store reads (two opacity
// ports, one edge port) overlap the previous word's write back; forwarding handles it.
// A four-word result queue decouples m_tready from s_tready (no combinational path).
// Reset: counters, pipeline and queue cleared at once; line store contents are not
// cleared, fill counts make never-written columns read as transparent / no edge.
module alpha_outline_extractor #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] alpha
    input  logic [1:0]  s_tuser,    // [0] frame_start, [1] pad

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] outline, [12:1] out_col, [24:13] out_row, rest 0
    output logic        m_tlast,    // last output pixel of the image

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [12:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RST_WIDTH = (int'(aoe_pkg::WIDTH_RST) > MAX_WIDTH) ?
                               MAX_WIDTH : int'(aoe_pkg::WIDTH_RST);
    localparam logic [CW-1:0] LAST_COL_RST = CW'(RST_WIDTH - 1);

    // ---------------- configuration ----------------
    // image width is kept as the index of the last column, already clamped
    logic [CW-1:0] last_col_reg;
    logic [CW-1:0] last_col_next;
    logic [7:0]    thr_reg;
    logic          cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data == 13'd0)
            last_col_next = '0;
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
            last_col_next = CW'(MAX_WIDTH - 1);
        else
            last_col_next = CW'(cfg_data - 13'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RST;
            thr_reg      <= aoe_pkg::THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (aoe_pkg::cfg_index_t'(cfg_addr))
                aoe_pkg::CFG_IMAGE_WIDTH:     last_col_reg <= last_col_next;
                aoe_pkg::CFG_ALPHA_THRESHOLD: thr_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A: accept, position, line store read ----------------
    logic          s_accept;
    logic          in_fs;
    logic          in_pad;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [12:0]   row_reg;
    logic [12:0]   row_next;
    logic [CW-1:0] col_clamp;
    logic [CW-1:0] a_col;
    logic [12:0]   a_row;
    logic          a_at_end;
    logic          a_opaque;
    logic [CW-1:0] a_side_addr;

    logic [aoe_pkg::OUT_CNT_W-1:0] q_count;

    assign in_fs  = s_tuser[0];
    assign in_pad = s_tuser[1];

    // a column past the last one (width shrunk mid row) is clamped and ends the row
    assign col_clamp = (col_reg > last_col_reg) ? last_col_reg : col_reg;
    assign a_col     = in_fs ? '0 : col_clamp;
    assign a_row     = in_fs ? 13'd0 : row_reg;
    assign a_at_end  = (a_col == last_col_reg);
    assign a_opaque  = !in_pad && (s_tdata > thr_reg);

    // side port: right neighbour inside a row, left neighbour at the last column
    assign a_side_addr = a_at_end ? (a_col - 1'b1) : (a_col + 1'b1);

    // room for the word in stage B plus this one in the result queue
    logic b_valid_reg;
    assign s_tready = ((q_count + aoe_pkg::OUT_CNT_W'(b_valid_reg))
                       < aoe_pkg::OUT_CNT_W'(aoe_pkg::OUT_DEPTH));
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (a_at_end)
        begin
            col_next = '0;
            row_next = (a_row == aoe_pkg::ROW_SAT) ? a_row : (a_row + 13'd1);
        end
        else
        begin
            col_next = a_col + 1'b1;
            row_next = a_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage B: neighbourhood, edge, write back ----------------
    logic [CW-1:0] b_col_reg;
    logic [12:0]   b_row_reg;
    logic          b_opaque_reg;
    logic          b_pad_reg;
    logic          b_at_end_reg;
    logic          b_col_nz_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            b_col_reg    <= a_col;
            b_row_reg    <= a_row;
            b_opaque_reg <= a_opaque;
            b_pad_reg    <= in_pad;
            b_at_end_reg <= a_at_end;
            b_col_nz_reg <= (a_col != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= s_accept;
    end

    aoe_pkg::line_wr_t lwr;
    aoe_pkg::line_rd_t lrd;

    aoe_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (s_accept),
        .rd_addr_here (a_col),
        .rd_addr_side (a_side_addr),
        .wr_addr      (b_col_reg),
        .wr           (lwr),
        .rd           (lrd)
    );

    // center opacity of the previous word; its written history bit 1 is the
    // left neighbour whenever that word sat in the column just before
    logic prev_center_reg;
    logic left_edge_reg;

    logic row_ge1;
    logic row_ge2;
    logic n_center;
    logic n_up;
    logic n_left;
    logic n_right;
    logic is_edge;
    logic horiz;
    logic above;

    assign row_ge1  = (b_row_reg != 13'd0);
    assign row_ge2  = (b_row_reg > 13'd1);
    assign n_center = lrd.opq_here[0];
    assign n_up     = row_ge2 && lrd.opq_here[1];
    assign n_left   = b_col_nz_reg &&
                      (b_at_end_reg ? lrd.opq_side[1] : prev_center_reg);
    assign n_right  = !b_at_end_reg && lrd.opq_side[0];
    assign is_edge  = n_center && !(n_up && n_left && n_right && b_opaque_reg);
    assign horiz    = is_edge || (b_col_nz_reg && left_edge_reg);
    assign above    = row_ge2 && lrd.edge_above;

    always_comb
    begin
        lwr.opq_en    = b_valid_reg;
        lwr.opq_data  = {lrd.opq_here[1:0], b_opaque_reg};
        lwr.edge_en   = b_valid_reg && row_ge1;
        lwr.edge_data = horiz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_edge_reg   <= 1'b0;
            prev_center_reg <= 1'b0;
        end
        else if (b_valid_reg)
        begin
            left_edge_reg   <= row_ge1 && is_edge;
            prev_center_reg <= n_center;
        end
    end

    // ---------------- result queue ----------------
    aoe_pkg::result_t res;
    aoe_pkg::result_t q_head;
    logic             res_push;

    assign res_push    = b_valid_reg && row_ge1;
    assign res.outline = horiz || above;
    assign res.col     = 12'(b_col_reg);
    assign res.row     = 12'(b_row_reg - 13'd1);
    assign res.last    = b_pad_reg && b_at_end_reg;

    aoe_out_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_head),
        .count     (q_count)
    );

    assign m_tdata = {7'd0, q_head.row, q_head.col, q_head.outline};
    assign m_tlast = q_head.last;

    a_accept_to_stage_b: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> b_valid_reg)
        else $error("accepted word did not reach stage B");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (q_count < aoe_pkg::OUT_CNT_W'(aoe_pkg::OUT_DEPTH)))
        else $error("result produced without queue room");

    a_row_hold_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !in_fs && !a_at_end) |=> (row_reg == $past(row_reg)))
        else $error("row count moved inside a row");

endmodule
